// ----- src/abps_pkg.sv -----
// ============================================================================
// abps_pkg
// Shared types, constants and helpers of the alpha-blend pixel store.
// ============================================================================
`default_nettype none

package abps_pkg;

    // Field widths
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned COLOR_W   = 32;
    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned CFG_W     = 10;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned ALPHA_LSB = 24;
    localparam int unsigned NUM_CHAN  = 3;
    localparam int unsigned PROD_W    = 2 * CHAN_W;

    // Default store geometry
    localparam int unsigned DEF_MAX_WIDTH  = 512;
    localparam int unsigned DEF_MAX_HEIGHT = 512;

    // Depth of the request queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     SCREEN_RESET      = CFG_W'(512);

    // Request kinds
    localparam logic ACT_WRITE = 1'b0;

    // Pixel constants
    localparam logic [COLOR_W-1:0] CLEAR_WORD   = 32'hFF00_0000;
    localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0]  ALPHA_CLEAR  = 8'h00;

    // Classified request handed from front to back
    typedef struct packed {
        logic               action;
        logic               in_bounds;
        logic [COLOR_W-1:0] color;
    } task_t;

    // Result word held in the output slot
    typedef struct packed {
        logic [COLOR_W-1:0] stored_color;
        logic               in_bounds;
        logic               wrote;
    } result_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WRITE
    } back_state_t;

    // floor(p / 255) for p <= 255*255, reciprocal form
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] t;
        t = (PROD_W+1)'(p) + (PROD_W+1)'(p >> CHAN_W) + (PROD_W+1)'(1);
        return t[PROD_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ----- src/abps_ram.sv -----
// ============================================================================
// abps_ram
// Generic single-port RAM, one read or write per cycle, registered read data.
// ============================================================================
`default_nettype none

module abps_ram
#(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read on the same port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- src/abps_queue.sv -----
// ============================================================================
// abps_queue
// Small register FIFO decoupling the request front from the pixel back end.
// ============================================================================
`default_nettype none

module abps_queue
#(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic      [WIDTH-1:0] dout
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = slot_reg[head_reg];

    // Pointer and fill-count update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + PW'(1);
        end
        if (pop)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ----- src/abps_front.sv -----
// ============================================================================
// abps_front
// Screen registers, request acceptance, bounds check and address generation.
// ============================================================================
`default_nettype none

module abps_front
    import abps_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int unsigned AW         = 18
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [CFG_W-1:0]     cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        action,
    input  wire logic signed [COORD_W-1:0]   x_pos,
    input  wire logic signed [COORD_W-1:0]   y_pos,
    input  wire logic        [COLOR_W-1:0]   color,
    input  wire logic                        q_full,
    input  wire logic                        clr_done,
    output logic                             q_push,
    output task_t                            q_task,
    output logic             [AW-1:0]        q_addr
);

    localparam int unsigned IW = 2 * CFG_W + 1;

    logic [CFG_W-1:0]   width_reg, width_next;
    logic [CFG_W-1:0]   height_reg, height_next;
    logic [CFG_W-1:0]   w_eff;
    logic [CFG_W-1:0]   h_eff;
    logic               x_ok;
    logic               y_ok;
    logic               in_b;
    logic [2*CFG_W-1:0] row_base;
    logic [IW-1:0]      pix_idx;

    // Configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_next  = cfg_data;
                REG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_RESET;
            height_reg <= SCREEN_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Saturate screen size to the store geometry
    assign w_eff = (COORD_W'(width_reg) > COORD_W'(MAX_WIDTH))
                   ? CFG_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (COORD_W'(height_reg) > COORD_W'(MAX_HEIGHT))
                   ? CFG_W'(MAX_HEIGHT) : height_reg;

    // Bounds check on signed coordinates
    assign x_ok = !x_pos[COORD_W-1] && ($unsigned(x_pos) < COORD_W'(w_eff));
    assign y_ok = !y_pos[COORD_W-1] && ($unsigned(y_pos) < COORD_W'(h_eff));
    assign in_b = x_ok && y_ok;

    // Linear address y*width + x
    assign row_base = (2*CFG_W)'(y_pos[CFG_W-1:0]) * (2*CFG_W)'(w_eff);
    assign pix_idx  = IW'(row_base) + IW'(x_pos[CFG_W-1:0]);

    // Hand the classified request to the queue
    assign full             = q_full || !clr_done;
    assign q_push           = push && !full;
    assign q_task.action    = action;
    assign q_task.in_bounds = in_b;
    assign q_task.color     = color;
    assign q_addr           = in_b ? AW'(pix_idx) : '0;

endmodule

`default_nettype wire

// ----- src/abps_back.sv -----
// ============================================================================
// abps_back
// Frame store sequencer: clearing pass, read, blend, write and result slot.
// ============================================================================
`default_nettype none

module abps_back
    import abps_pkg::*;
#(
    parameter int unsigned DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int unsigned AW    = 18
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire task_t         q_task,
    input  wire logic [AW-1:0] q_addr,
    output logic               clr_done,
    input  wire logic          pop,
    output logic               empty,
    output result_t            res
);

    back_state_t        state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg;
    task_t              task_reg;
    logic [AW-1:0]      addr_reg;
    logic [COLOR_W-1:0] dst_reg;
    logic [PROD_W-1:0]  prod_src_reg [NUM_CHAN];
    logic [PROD_W-1:0]  prod_dst_reg [NUM_CHAN];

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;

    logic               out_free;
    logic               push_out;
    logic [CHAN_W-1:0]  alpha;
    logic [CHAN_W-1:0]  alpha_inv;
    logic               write_en;
    logic [COLOR_W-1:0] blend_word;
    logic [COLOR_W-1:0] new_word;
    result_t            res_next;

    abps_ram #(
        .WIDTH  (COLOR_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || pop;
    assign alpha     = task_reg.color[ALPHA_LSB +: CHAN_W];
    assign alpha_inv = ALPHA_OPAQUE - alpha;
    assign write_en  = task_reg.in_bounds && (task_reg.action == ACT_WRITE)
                       && (alpha != ALPHA_CLEAR);

    // Per-channel blend from registered products
    always_comb
    begin
        blend_word = '0;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            blend_word[c*CHAN_W +: CHAN_W] = div255(prod_src_reg[c])
                                             + div255(prod_dst_reg[c]);
        end
        blend_word[ALPHA_LSB +: CHAN_W] = ALPHA_CLEAR;
    end

    assign new_word = (alpha == ALPHA_OPAQUE) ? task_reg.color : blend_word;

    always_comb
    begin
        res_next.in_bounds    = task_reg.in_bounds;
        res_next.wrote        = write_en;
        res_next.stored_color = !task_reg.in_bounds ? '0
                                : (write_en ? new_word : dst_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        push_out     = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = q_addr;
        ram_wdata    = CLEAR_WORD;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ram_we     = write_en;
                ram_addr   = addr_reg;
                ram_wdata  = new_word;
                push_out   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            task_reg <= q_task;
            addr_reg <= q_addr;
        end
        if (state_reg == ST_CALC)
        begin
            dst_reg <= ram_rdata;
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                prod_src_reg[c] <= PROD_W'(task_reg.color[c*CHAN_W +: CHAN_W])
                                   * PROD_W'(alpha);
                prod_dst_reg[c] <= PROD_W'(ram_rdata[c*CHAN_W +: CHAN_W])
                                   * PROD_W'(alpha_inv);
            end
        end
        if (push_out)
        begin
            out_res_reg <= res_next;
        end
    end

    assign clr_done = (state_reg != ST_CLEAR);
    assign empty    = !out_valid_reg;
    assign res      = out_res_reg;

endmodule

`default_nettype wire

// ----- src/alpha_blend_pixel_store.sv -----
// ============================================================================
// alpha_blend_pixel_store
// Frame store of ARGB words with a single-pixel source-over blend engine.
// ============================================================================
// Usage:
//   Requests enter through push/full: action 0 blends color into the pixel at
//   (x_pos, y_pos), action 1 reads it. Results leave through empty/pop, one
//   per request, in request order.
//   Screen size is set through cfg_valid/cfg_ready (index 0 width, 1 height),
//   written by the user only while no request is in flight (not enforced).
//   cfg_ready is always high. Each taken request is read from the store,
//   multiplied, then blended and written back on the single frame-store
//   port; the engine takes no new request until that write is done.
//   A two-entry request queue keeps push open while the engine works and
//   while a finished result waits on a stalled pop.
//   Reset: the store is cleared to opaque black by a pass over all
//   MAX_WIDTH*MAX_HEIGHT words (262144 with the defaults), one word per
//   cycle; full stays high until it ends.
//   Stall: while pop is low the result holds, the engine stops once the
//   result slot is occupied, and full rises once the request queue fills.
// ============================================================================
`default_nettype none

module alpha_blend_pixel_store
    import abps_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [CFG_W-1:0]     cfg_data,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic                        action,
    input  wire logic signed [COORD_W-1:0]   x_pos,
    input  wire logic signed [COORD_W-1:0]   y_pos,
    input  wire logic        [COLOR_W-1:0]   color,
    output logic                             empty,
    input  wire logic                        pop,
    output logic             [COLOR_W-1:0]   stored_color,
    output logic                             in_bounds,
    output logic                             wrote
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned QW    = $bits(task_t) + AW;

    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    logic          clr_done;
    task_t         push_task;
    logic [AW-1:0] push_addr;
    logic [QW-1:0] q_din;
    logic [QW-1:0] q_dout;
    task_t         head_task;
    logic [AW-1:0] head_addr;
    result_t       res;

    abps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .action    (action),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .color     (color),
        .q_full    (q_full),
        .clr_done  (clr_done),
        .q_push    (q_push),
        .q_task    (push_task),
        .q_addr    (push_addr)
    );

    assign q_din                  = {push_task, push_addr};
    assign {head_task, head_addr} = q_dout;

    abps_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    abps_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_task   (head_task),
        .q_addr   (head_addr),
        .clr_done (clr_done),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    assign stored_color = res.stored_color;
    assign in_bounds    = res.in_bounds;
    assign wrote        = res.wrote;

endmodule

`default_nettype wire

// ----- src/abps_checker.sv -----
// ============================================================================
// abps_checker
// Port-level checks of the pixel store, bound to the top level.
// ============================================================================
`default_nettype none

module abps_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] stored_color,
    input wire logic        in_bounds,
    input wire logic        wrote
);

    // A change to the store needs an on-screen pixel
    a_wrote_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && wrote |-> in_bounds)
        else $error("write reported for an off-screen pixel");

    // Off-screen results carry a zero word and no write
    a_offscreen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !in_bounds |-> (stored_color == 32'h0) && !wrote)
        else $error("off-screen result not cleared");

    // A written word is either an opaque copy or a blend with alpha cleared
    a_written_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && wrote |-> (stored_color[31:24] == 8'h00)
                            || (stored_color[31:24] == 8'hFF))
        else $error("written word has an impossible alpha byte");

    // A waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(stored_color) && $stable(wrote))
        else $error("result changed while stalled");

endmodule

bind alpha_blend_pixel_store abps_checker u_abps_checker (.*);

`default_nettype wire
